### sv/nnr_pkg.sv
package nnr_pkg;

    localparam int POS_W     = 10;
    localparam int CHAN_W    = 2;
    localparam int SMP_W     = 16;
    localparam int COORD_W   = 8;
    localparam int SRC_DIM_W = 9;
    localparam int DST_DIM_W = 11;
    localparam int NCH_W     = 3;
    localparam int PADDR_W   = 5;
    localparam int PDATA_W   = 32;
    localparam int REGIDX_W  = 3;

    localparam int DEF_MAX_SRC_W    = 256;
    localparam int DEF_MAX_SRC_H    = 256;
    localparam int DEF_MAX_CHANNELS = 4;
    localparam int DEF_SAMPLE_BITS  = 16;

    localparam logic CMD_LOAD  = 1'b0;
    localparam logic CMD_FETCH = 1'b1;

    localparam logic [REGIDX_W-1:0] REG_SRC_WIDTH  = 3'd0;
    localparam logic [REGIDX_W-1:0] REG_SRC_HEIGHT = 3'd1;
    localparam logic [REGIDX_W-1:0] REG_DST_WIDTH  = 3'd2;
    localparam logic [REGIDX_W-1:0] REG_DST_HEIGHT = 3'd3;
    localparam logic [REGIDX_W-1:0] REG_CHANNELS   = 3'd4;

    localparam logic [SRC_DIM_W-1:0] RST_SRC_WIDTH  = 9'd256;
    localparam logic [SRC_DIM_W-1:0] RST_SRC_HEIGHT = 9'd256;
    localparam logic [DST_DIM_W-1:0] RST_DST_WIDTH  = 11'd256;
    localparam logic [DST_DIM_W-1:0] RST_DST_HEIGHT = 11'd256;
    localparam logic [NCH_W-1:0]     RST_CHANNELS   = 3'd3;

    typedef struct packed {
        logic accept;
        logic calc;
        logic div_start;
        logic sel_row;
        logic col_load;
        logic row_load;
        logic ram_rd;
        logic out_load;
    } nnr_cmd_t;

    typedef struct packed {
        logic is_fetch;
        logic err;
        logic div_done;
    } nnr_status_t;

endpackage

### sv/nnr_ram.sv
module nnr_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

### sv/nnr_div.sv
// Restoring divider, one quotient bit per cycle. The quotient must fit in Q_W bits,
// so the upper numerator bits already lie below the divisor and seed the remainder.
module nnr_div #(
    parameter int NUM_W = 20,
    parameter int DEN_W = 12,
    parameter int Q_W   = 8
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [NUM_W-1:0] num,
    input  logic [DEN_W-1:0] den,
    output logic             done,
    output logic [Q_W-1:0]   quot
);

    localparam int CNT_W = $clog2(Q_W + 1);

    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [DEN_W-1:0] rem_reg, rem_next;
    logic [DEN_W-1:0] den_reg, den_next;
    logic [Q_W-1:0]   quot_reg, quot_next;
    logic [DEN_W:0]   shifted;
    logic             fits;

    assign shifted = {rem_reg, quot_reg[Q_W-1]};
    assign fits    = shifted >= {1'b0, den_reg};

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;
        quot_next = quot_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = CNT_W'(Q_W);
            rem_next  = DEN_W'(num[NUM_W-1:Q_W]);
            den_next  = den;
            quot_next = num[Q_W-1:0];
        end
        else if (busy_reg)
        begin
            rem_next  = fits ? DEN_W'(shifted - {1'b0, den_reg}) : DEN_W'(shifted);
            quot_next = Q_W'({quot_reg, fits});
            cnt_next  = cnt_reg - 1'b1;
            if (cnt_reg == CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg  <= rem_next;
        den_reg  <= den_next;
        quot_reg <= quot_next;
    end

    assign done = done_reg;
    assign quot = quot_reg;

endmodule

### sv/nnr_datapath.sv
module nnr_datapath #(
    parameter int MAX_SRC_W    = nnr_pkg::DEF_MAX_SRC_W,
    parameter int MAX_SRC_H    = nnr_pkg::DEF_MAX_SRC_H,
    parameter int MAX_CHANNELS = nnr_pkg::DEF_MAX_CHANNELS,
    parameter int SAMPLE_BITS  = nnr_pkg::DEF_SAMPLE_BITS
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  nnr_pkg::nnr_cmd_t               ctl,
    output nnr_pkg::nnr_status_t            stat,
    input  logic [nnr_pkg::SRC_DIM_W-1:0]   src_width,
    input  logic [nnr_pkg::SRC_DIM_W-1:0]   src_height,
    input  logic [nnr_pkg::DST_DIM_W-1:0]   dst_width,
    input  logic [nnr_pkg::DST_DIM_W-1:0]   dst_height,
    input  logic [nnr_pkg::NCH_W-1:0]       channels,
    input  logic                            cmd,
    input  logic [nnr_pkg::POS_W-1:0]       pos_x,
    input  logic [nnr_pkg::POS_W-1:0]       pos_y,
    input  logic [nnr_pkg::CHAN_W-1:0]      chan,
    input  logic [nnr_pkg::SMP_W-1:0]       sample_in,
    output logic [nnr_pkg::SMP_W-1:0]       sample_out,
    output logic [nnr_pkg::COORD_W-1:0]     src_col,
    output logic [nnr_pkg::COORD_W-1:0]     src_row,
    output logic                            range_error
);

    import nnr_pkg::*;

    localparam int DIM_MAX = (MAX_SRC_W > MAX_SRC_H) ? MAX_SRC_W : MAX_SRC_H;
    localparam int Q_W     = (DIM_MAX > 1) ? $clog2(DIM_MAX) : 1;
    localparam int DIM_W   = $clog2(DIM_MAX + 1);
    localparam int SW_W    = $clog2(MAX_SRC_W + 1);
    localparam int SH_W    = $clog2(MAX_SRC_H + 1);
    localparam int NC_W    = $clog2(MAX_CHANNELS + 1);
    localparam int ODD_W   = POS_W + 1;
    localparam int NUM_W   = ODD_W + DIM_W;
    localparam int DEN_W   = DST_DIM_W + 1;
    localparam int DEPTH   = MAX_SRC_W * MAX_SRC_H * MAX_CHANNELS;
    localparam int ADDR_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int ROW_STRIDE = MAX_SRC_W * MAX_CHANNELS;

    logic [SW_W-1:0] sw;
    logic [SH_W-1:0] sh;
    logic [NC_W-1:0] nc;

    assign sw = (32'(src_width) > 32'(MAX_SRC_W)) ? SW_W'(MAX_SRC_W) : SW_W'(src_width);
    assign sh = (32'(src_height) > 32'(MAX_SRC_H)) ? SH_W'(MAX_SRC_H) : SH_W'(src_height);
    assign nc = (32'(channels) > 32'(MAX_CHANNELS)) ? NC_W'(MAX_CHANNELS) : NC_W'(channels);

    logic              load_ok;
    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr;

    assign load_ok = (cmd == CMD_LOAD) && (32'(pos_x) < 32'(sw)) && (32'(pos_y) < 32'(sh))
                     && (32'(chan) < 32'(nc));
    assign wr_en   = ctl.accept && load_ok;
    assign wr_addr = ADDR_W'(pos_y) * ADDR_W'(ROW_STRIDE)
                     + ADDR_W'(pos_x) * ADDR_W'(MAX_CHANNELS) + ADDR_W'(chan);

    logic [POS_W-1:0]  pos_x_reg, pos_y_reg;
    logic [CHAN_W-1:0] chan_reg;
    logic [NUM_W-1:0]  num_col_reg, num_row_reg;
    logic              err_reg;
    logic [Q_W-1:0]    col_reg, row_reg;
    logic [SMP_W-1:0]  sample_out_reg;
    logic [COORD_W-1:0] src_col_reg, src_row_reg;
    logic              range_error_reg;

    logic fetch_err;

    assign fetch_err = (sw == '0) || (sh == '0) || (nc == '0)
                       || (32'(pos_x_reg) >= 32'(dst_width))
                       || (32'(pos_y_reg) >= 32'(dst_height))
                       || (32'(chan_reg) >= 32'(nc));

    logic [NUM_W-1:0] div_num;
    logic [DEN_W-1:0] div_den;
    logic             div_done;
    logic [Q_W-1:0]   div_quot;

    assign div_num = ctl.sel_row ? num_row_reg : num_col_reg;
    assign div_den = ctl.sel_row ? {dst_height, 1'b0} : {dst_width, 1'b0};

    nnr_div #(
        .NUM_W (NUM_W),
        .DEN_W (DEN_W),
        .Q_W   (Q_W)
    ) u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (ctl.div_start),
        .num   (div_num),
        .den   (div_den),
        .done  (div_done),
        .quot  (div_quot)
    );

    logic [ADDR_W-1:0]      rd_addr;
    logic [SAMPLE_BITS-1:0] rd_data;

    assign rd_addr = ADDR_W'(row_reg) * ADDR_W'(ROW_STRIDE)
                     + ADDR_W'(col_reg) * ADDR_W'(MAX_CHANNELS) + ADDR_W'(chan_reg);

    nnr_ram #(
        .WIDTH (SAMPLE_BITS),
        .DEPTH (DEPTH),
        .AW    (ADDR_W)
    ) u_store (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (SAMPLE_BITS'(sample_in)),
        .rd_en   (ctl.ram_rd),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    always_ff @(posedge clk)
    begin
        if (ctl.accept)
        begin
            pos_x_reg <= pos_x;
            pos_y_reg <= pos_y;
            chan_reg  <= chan;
        end
        if (ctl.calc)
        begin
            num_col_reg <= NUM_W'({pos_x_reg, 1'b1}) * NUM_W'(sw);
            num_row_reg <= NUM_W'({pos_y_reg, 1'b1}) * NUM_W'(sh);
            err_reg     <= fetch_err;
        end
        if (ctl.col_load)
        begin
            col_reg <= div_quot;
        end
        if (ctl.row_load)
        begin
            row_reg <= div_quot;
        end
        if (ctl.out_load)
        begin
            sample_out_reg  <= err_reg ? '0 : SMP_W'(rd_data);
            src_col_reg     <= err_reg ? '0 : COORD_W'(col_reg);
            src_row_reg     <= err_reg ? '0 : COORD_W'(row_reg);
            range_error_reg <= err_reg;
        end
    end

    assign stat.is_fetch = (cmd == CMD_FETCH);
    assign stat.err      = fetch_err;
    assign stat.div_done = div_done;

    assign sample_out  = sample_out_reg;
    assign src_col     = src_col_reg;
    assign src_row     = src_row_reg;
    assign range_error = range_error_reg;

endmodule

### sv/nnr_ctrl.sv
module nnr_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    output logic                 out_valid,
    input  logic                 out_ready,
    input  nnr_pkg::nnr_status_t stat,
    output nnr_pkg::nnr_cmd_t    ctl
);

    import nnr_pkg::*;

    typedef enum logic [7:0] {
        S_IDLE    = 8'b0000_0001,
        S_CALC    = 8'b0000_0010,
        S_COL_GO  = 8'b0000_0100,
        S_COL_RUN = 8'b0000_1000,
        S_ROW_GO  = 8'b0001_0000,
        S_ROW_RUN = 8'b0010_0000,
        S_READ    = 8'b0100_0000,
        S_DELIVER = 8'b1000_0000
    } state_t;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;
    logic   out_free;

    assign out_free = !out_valid_reg || out_ready;

    always_comb
    begin
        state_next = state_reg;
        ctl        = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                ctl.accept = in_valid;
                if (in_valid && stat.is_fetch)
                begin
                    state_next = S_CALC;
                end
            end
            S_CALC:
            begin
                ctl.calc   = 1'b1;
                state_next = stat.err ? S_DELIVER : S_COL_GO;
            end
            S_COL_GO:
            begin
                ctl.div_start = 1'b1;
                state_next    = S_COL_RUN;
            end
            S_COL_RUN:
            begin
                if (stat.div_done)
                begin
                    ctl.col_load = 1'b1;
                    state_next   = S_ROW_GO;
                end
            end
            S_ROW_GO:
            begin
                ctl.div_start = 1'b1;
                ctl.sel_row   = 1'b1;
                state_next    = S_ROW_RUN;
            end
            S_ROW_RUN:
            begin
                ctl.sel_row = 1'b1;
                if (stat.div_done)
                begin
                    ctl.row_load = 1'b1;
                    state_next   = S_READ;
                end
            end
            S_READ:
            begin
                ctl.ram_rd = 1'b1;
                state_next = S_DELIVER;
            end
            S_DELIVER:
            begin
                if (out_free)
                begin
                    ctl.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (ctl.out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;

endmodule

### sv/nearest_neighbor_resize.sv
// A load beat is written at the edge that accepts it, and loads can follow every cycle
// while no fetch is in flight. A fetch beat is registered, then divided for its column
// and then its row, and its sample is read from the frame store before the result is
// registered; an out-of-range fetch skips the divides and the read. Only one fetch is in
// flight: the next beat is taken once the result has been loaded into a free output register.
// Reset is asynchronous and active low; it restores the size registers, the frame store is not cleared.
module nearest_neighbor_resize #(
    parameter int MAX_SRC_W    = nnr_pkg::DEF_MAX_SRC_W,
    parameter int MAX_SRC_H    = nnr_pkg::DEF_MAX_SRC_H,
    parameter int MAX_CHANNELS = nnr_pkg::DEF_MAX_CHANNELS,
    parameter int SAMPLE_BITS  = nnr_pkg::DEF_SAMPLE_BITS
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [nnr_pkg::PADDR_W-1:0]   paddr,
    input  logic [nnr_pkg::PDATA_W-1:0]   pwdata,
    output logic [nnr_pkg::PDATA_W-1:0]   prdata,
    output logic                          pready,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic                          cmd,
    input  logic [nnr_pkg::POS_W-1:0]     pos_x,
    input  logic [nnr_pkg::POS_W-1:0]     pos_y,
    input  logic [nnr_pkg::CHAN_W-1:0]    chan,
    input  logic [nnr_pkg::SMP_W-1:0]     sample_in,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [nnr_pkg::SMP_W-1:0]     sample_out,
    output logic [nnr_pkg::COORD_W-1:0]   src_col,
    output logic [nnr_pkg::COORD_W-1:0]   src_row,
    output logic                          range_error
);

    import nnr_pkg::*;

    logic [SRC_DIM_W-1:0] src_width_reg, src_width_next;
    logic [SRC_DIM_W-1:0] src_height_reg, src_height_next;
    logic [DST_DIM_W-1:0] dst_width_reg, dst_width_next;
    logic [DST_DIM_W-1:0] dst_height_reg, dst_height_next;
    logic [NCH_W-1:0]     channels_reg, channels_next;
    logic                 cfg_wr;
    logic [REGIDX_W-1:0]  reg_idx;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite;
    assign reg_idx = paddr[PADDR_W-1:2];

    always_comb
    begin
        src_width_next  = src_width_reg;
        src_height_next = src_height_reg;
        dst_width_next  = dst_width_reg;
        dst_height_next = dst_height_reg;
        channels_next   = channels_reg;
        if (cfg_wr)
        begin
            unique case (reg_idx)
                REG_SRC_WIDTH:  src_width_next  = pwdata[SRC_DIM_W-1:0];
                REG_SRC_HEIGHT: src_height_next = pwdata[SRC_DIM_W-1:0];
                REG_DST_WIDTH:  dst_width_next  = pwdata[DST_DIM_W-1:0];
                REG_DST_HEIGHT: dst_height_next = pwdata[DST_DIM_W-1:0];
                REG_CHANNELS:   channels_next   = pwdata[NCH_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            src_width_reg  <= RST_SRC_WIDTH;
            src_height_reg <= RST_SRC_HEIGHT;
            dst_width_reg  <= RST_DST_WIDTH;
            dst_height_reg <= RST_DST_HEIGHT;
            channels_reg   <= RST_CHANNELS;
        end
        else
        begin
            src_width_reg  <= src_width_next;
            src_height_reg <= src_height_next;
            dst_width_reg  <= dst_width_next;
            dst_height_reg <= dst_height_next;
            channels_reg   <= channels_next;
        end
    end

    always_comb
    begin
        unique case (reg_idx)
            REG_SRC_WIDTH:  prdata = PDATA_W'(src_width_reg);
            REG_SRC_HEIGHT: prdata = PDATA_W'(src_height_reg);
            REG_DST_WIDTH:  prdata = PDATA_W'(dst_width_reg);
            REG_DST_HEIGHT: prdata = PDATA_W'(dst_height_reg);
            REG_CHANNELS:   prdata = PDATA_W'(channels_reg);
            default:        prdata = '0;
        endcase
    end

    nnr_cmd_t    ctl;
    nnr_status_t stat;

    nnr_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .stat      (stat),
        .ctl       (ctl)
    );

    nnr_datapath #(
        .MAX_SRC_W    (MAX_SRC_W),
        .MAX_SRC_H    (MAX_SRC_H),
        .MAX_CHANNELS (MAX_CHANNELS),
        .SAMPLE_BITS  (SAMPLE_BITS)
    ) u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .ctl         (ctl),
        .stat        (stat),
        .src_width   (src_width_reg),
        .src_height  (src_height_reg),
        .dst_width   (dst_width_reg),
        .dst_height  (dst_height_reg),
        .channels    (channels_reg),
        .cmd         (cmd),
        .pos_x       (pos_x),
        .pos_y       (pos_y),
        .chan        (chan),
        .sample_in   (sample_in),
        .sample_out  (sample_out),
        .src_col     (src_col),
        .src_row     (src_row),
        .range_error (range_error)
    );

endmodule

### sim/resize_checker.sv
module resize_checker (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic                        pready,
    input  logic [nnr_pkg::PADDR_W-1:0] paddr,
    input  logic [nnr_pkg::PDATA_W-1:0] pwdata,
    input  logic                        in_valid,
    input  logic                        in_ready,
    input  logic                        cmd,
    input  logic [nnr_pkg::POS_W-1:0]   pos_x,
    input  logic [nnr_pkg::POS_W-1:0]   pos_y,
    input  logic [nnr_pkg::CHAN_W-1:0]  chan,
    input  logic [nnr_pkg::SMP_W-1:0]   sample_in,
    input  logic                        out_valid,
    input  logic                        out_ready,
    input  logic [nnr_pkg::SMP_W-1:0]   sample_out,
    input  logic [nnr_pkg::COORD_W-1:0] src_col,
    input  logic [nnr_pkg::COORD_W-1:0] src_row,
    input  logic                        range_error,
    output int                          mismatch_count,
    output int                          outstanding
);
    timeunit 1ns;
    timeprecision 1ps;

    import nnr_pkg::*;

    localparam int STORE_SLOTS = DEF_MAX_SRC_W * DEF_MAX_SRC_H * DEF_MAX_CHANNELS;

    typedef struct packed {
        logic [SMP_W-1:0]   sample;
        logic [COORD_W-1:0] col;
        logic [COORD_W-1:0] row;
        logic               err;
    } pixel_result_t;

    logic [SRC_DIM_W-1:0] src_w_reg;
    logic [SRC_DIM_W-1:0] src_h_reg;
    logic [DST_DIM_W-1:0] dst_w_reg;
    logic [DST_DIM_W-1:0] dst_h_reg;
    logic [NCH_W-1:0]     chans_reg;
    logic [SMP_W-1:0]     frame_model [0:STORE_SLOTS-1];
    pixel_result_t        expected_pixels [$];
    pixel_result_t        oldest;

    function automatic int limit_size(input int v, input int lim);
        return (v > lim) ? lim : v;
    endfunction

    function automatic int slot_of(input int col, input int row, input int ch);
        return (row * DEF_MAX_SRC_W + col) * DEF_MAX_CHANNELS + ch;
    endfunction

    function automatic pixel_result_t predict_pixel(input int px, input int py, input int ch);
        pixel_result_t res;
        int sw, sh, nc, dw, dh, col, row;
        sw = limit_size(int'(src_w_reg), DEF_MAX_SRC_W);
        sh = limit_size(int'(src_h_reg), DEF_MAX_SRC_H);
        nc = limit_size(int'(chans_reg), DEF_MAX_CHANNELS);
        dw = int'(dst_w_reg);
        dh = int'(dst_h_reg);
        res = '0;
        if (sw == 0 || sh == 0 || nc == 0 || dw == 0 || dh == 0 ||
            px >= dw || py >= dh || ch >= nc)
        begin
            res.err = 1'b1;
            return res;
        end
        col = ((2 * px + 1) * sw) / (2 * dw);
        row = ((2 * py + 1) * sh) / (2 * dh);
        if (col >= sw)
        begin
            col = sw - 1;
        end
        if (row >= sh)
        begin
            row = sh - 1;
        end
        res.sample = frame_model[slot_of(col, row, ch)];
        res.col    = col[COORD_W-1:0];
        res.row    = row[COORD_W-1:0];
        return res;
    endfunction

    task automatic store_sample(input int px, input int py, input int ch,
                                input logic [SMP_W-1:0] value);
        int sw, sh, nc;
        sw = limit_size(int'(src_w_reg), DEF_MAX_SRC_W);
        sh = limit_size(int'(src_h_reg), DEF_MAX_SRC_H);
        nc = limit_size(int'(chans_reg), DEF_MAX_CHANNELS);
        if (px < sw && py < sh && ch < nc)
        begin
            frame_model[slot_of(px, py, ch)] = value;
        end
    endtask

    task automatic write_register(input logic [REGIDX_W-1:0] idx,
                                  input logic [PDATA_W-1:0] data);
        case (idx)
            REG_SRC_WIDTH:  src_w_reg = data[SRC_DIM_W-1:0];
            REG_SRC_HEIGHT: src_h_reg = data[SRC_DIM_W-1:0];
            REG_DST_WIDTH:  dst_w_reg = data[DST_DIM_W-1:0];
            REG_DST_HEIGHT: dst_h_reg = data[DST_DIM_W-1:0];
            REG_CHANNELS:   chans_reg = data[NCH_W-1:0];
            default: ;
        endcase
    endtask

    task automatic compare_field(input string name, input logic [SMP_W-1:0] want,
                                 input logic [SMP_W-1:0] got);
        if (got !== want)
        begin
            $error("%s mismatch: expected %0h, actual %0h", name, want, got);
            mismatch_count++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            src_w_reg = RST_SRC_WIDTH;
            src_h_reg = RST_SRC_HEIGHT;
            dst_w_reg = RST_DST_WIDTH;
            dst_h_reg = RST_DST_HEIGHT;
            chans_reg = RST_CHANNELS;
            expected_pixels.delete();
            mismatch_count = 0;
            outstanding <= 0;
        end
        else
        begin
            if (psel && penable && pwrite && pready)
            begin
                write_register(paddr[PADDR_W-1:2], pwdata);
            end
            if (out_valid && out_ready)
            begin
                if (expected_pixels.size() == 0)
                begin
                    $error("result beat arrived with nothing expected");
                    mismatch_count++;
                end
                else
                begin
                    oldest = expected_pixels.pop_front();
                    compare_field("sample_out", oldest.sample, sample_out);
                    compare_field("src_col", SMP_W'(oldest.col), SMP_W'(src_col));
                    compare_field("src_row", SMP_W'(oldest.row), SMP_W'(src_row));
                    compare_field("range_error", SMP_W'(oldest.err), SMP_W'(range_error));
                end
            end
            if (in_valid && in_ready)
            begin
                if (cmd == CMD_LOAD)
                begin
                    store_sample(int'(pos_x), int'(pos_y), int'(chan), sample_in);
                end
                else
                begin
                    expected_pixels.push_back(predict_pixel(int'(pos_x), int'(pos_y),
                                                            int'(chan)));
                end
            end
            outstanding <= expected_pixels.size();
        end
    end

endmodule

### sim/tb_top.sv
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import nnr_pkg::*;

    localparam int STORE_SLOTS  = DEF_MAX_SRC_W * DEF_MAX_SRC_H * DEF_MAX_CHANNELS;
    localparam int SETTLE       = 30;
    localparam int HOLD_CYCLES  = 200;
    localparam int LIMIT_CYCLES = 1000000;
    localparam int PHASES       = 12;
    localparam int PHASE_ITEMS  = 150;
    localparam logic [REGIDX_W-1:0] REG_SPARE = REG_CHANNELS + 3'd1;

    logic                 clk;
    logic                 rst_n;
    logic                 psel;
    logic                 penable;
    logic                 pwrite;
    logic [PADDR_W-1:0]   paddr;
    logic [PDATA_W-1:0]   pwdata;
    logic [PDATA_W-1:0]   prdata;
    logic                 pready;
    logic                 in_valid;
    logic                 in_ready;
    logic                 cmd;
    logic [POS_W-1:0]     pos_x;
    logic [POS_W-1:0]     pos_y;
    logic [CHAN_W-1:0]    chan;
    logic [SMP_W-1:0]     sample_in;
    logic                 out_valid;
    logic                 out_ready;
    logic [SMP_W-1:0]     sample_out;
    logic [COORD_W-1:0]   src_col;
    logic [COORD_W-1:0]   src_row;
    logic                 range_error;

    int fail_count;
    int pending_count;
    int cycle_count;
    int items_sent;
    int hold_asked;
    int hold_served;
    bit calm;
    bit loaded [0:STORE_SLOTS-1];

    logic [SRC_DIM_W-1:0] cfg_sw;
    logic [SRC_DIM_W-1:0] cfg_sh;
    logic [DST_DIM_W-1:0] cfg_dw;
    logic [DST_DIM_W-1:0] cfg_dh;
    logic [NCH_W-1:0]     cfg_nc;

    nearest_neighbor_resize uut (
        .clk         (clk),
        .rst_n       (rst_n),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .cmd         (cmd),
        .pos_x       (pos_x),
        .pos_y       (pos_y),
        .chan        (chan),
        .sample_in   (sample_in),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .sample_out  (sample_out),
        .src_col     (src_col),
        .src_row     (src_row),
        .range_error (range_error)
    );

    resize_checker chk (
        .clk            (clk),
        .rst_n          (rst_n),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .pready         (pready),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .cmd            (cmd),
        .pos_x          (pos_x),
        .pos_y          (pos_y),
        .chan           (chan),
        .sample_in      (sample_in),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .sample_out     (sample_out),
        .src_col        (src_col),
        .src_row        (src_row),
        .range_error    (range_error),
        .mismatch_count (fail_count),
        .outstanding    (pending_count)
    );

    always
    begin
        clk = 1'b0;
        #6;
        clk = 1'b1;
        #6;
    end

    initial
    begin
        cycle_count = 0;
        while (cycle_count < LIMIT_CYCLES)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("RESULT: ERROR");
        $finish;
    end

    // Receiver side: random stretches of ready and stall, plus a long hold-off on request.
    initial
    begin
        int r;
        int span;
        out_ready   = 1'b0;
        hold_served = 0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(negedge clk);
            if (hold_served != hold_asked)
            begin
                out_ready <= 1'b0;
                repeat (HOLD_CYCLES - 1) @(negedge clk);
                hold_served++;
            end
            else if (calm)
            begin
                out_ready <= 1'b1;
            end
            else
            begin
                r = $urandom_range(0, 99);
                if (r < 60)
                begin
                    out_ready <= 1'b1;
                    span = $urandom_range(1, 30);
                end
                else if (r < 92)
                begin
                    out_ready <= 1'b0;
                    span = $urandom_range(1, 4);
                end
                else
                begin
                    out_ready <= 1'b0;
                    span = $urandom_range(10, 40);
                end
                repeat (span - 1) @(negedge clk);
            end
        end
    end

    function automatic int limit_size(input int v, input int lim);
        return (v > lim) ? lim : v;
    endfunction

    function automatic int nearest_src(input int d, input int s, input int dd);
        return ((2 * d + 1) * s) / (2 * dd);
    endfunction

    function automatic int slot_of(input int col, input int row, input int ch);
        return (row * DEF_MAX_SRC_W + col) * DEF_MAX_CHANNELS + ch;
    endfunction

    function automatic int pick_below(input int n);
        return (n > 0) ? $urandom_range(0, n - 1) : 0;
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (calm || r < 70)
        begin
            return 0;
        end
        return (r < 95) ? $urandom_range(1, 3) : $urandom_range(8, 40);
    endfunction

    task automatic push_beat(input logic c, input logic [POS_W-1:0] x,
                             input logic [POS_W-1:0] y, input logic [CHAN_W-1:0] ch,
                             input logic [SMP_W-1:0] smp);
        int gap;
        gap = pick_gap();
        @(negedge clk);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        cmd       <= c;
        pos_x     <= x;
        pos_y     <= y;
        chan      <= ch;
        sample_in <= smp;
        in_valid  <= 1'b1;
        @(posedge clk);
        while (!in_ready)
        begin
            @(posedge clk);
        end
        items_sent++;
    endtask

    task automatic load_beat(input logic [POS_W-1:0] x, input logic [POS_W-1:0] y,
                             input logic [CHAN_W-1:0] ch, input logic [SMP_W-1:0] smp);
        int sw, sh, nc;
        sw = limit_size(int'(cfg_sw), DEF_MAX_SRC_W);
        sh = limit_size(int'(cfg_sh), DEF_MAX_SRC_H);
        nc = limit_size(int'(cfg_nc), DEF_MAX_CHANNELS);
        push_beat(CMD_LOAD, x, y, ch, smp);
        if (int'(x) < sw && int'(y) < sh && int'(ch) < nc)
        begin
            loaded[slot_of(int'(x), int'(y), int'(ch))] = 1'b1;
        end
    endtask

    // A fetch whose source sample was never written gets that sample loaded first.
    task automatic fetch_beat(input logic [POS_W-1:0] x, input logic [POS_W-1:0] y,
                              input logic [CHAN_W-1:0] ch);
        int sw, sh, nc, col, row;
        logic [31:0] junk;
        sw = limit_size(int'(cfg_sw), DEF_MAX_SRC_W);
        sh = limit_size(int'(cfg_sh), DEF_MAX_SRC_H);
        nc = limit_size(int'(cfg_nc), DEF_MAX_CHANNELS);
        junk = $urandom;
        if (sw > 0 && sh > 0 && int'(x) < int'(cfg_dw) && int'(y) < int'(cfg_dh) &&
            int'(ch) < nc)
        begin
            col = limit_size(nearest_src(int'(x), sw, int'(cfg_dw)), sw - 1);
            row = limit_size(nearest_src(int'(y), sh, int'(cfg_dh)), sh - 1);
            if (!loaded[slot_of(col, row, int'(ch))])
            begin
                load_beat(POS_W'(col), POS_W'(row), ch, junk[SMP_W-1:0]);
            end
        end
        push_beat(CMD_FETCH, x, y, ch, junk[31:32-SMP_W]);
    endtask

    task automatic random_beat();
        int sw, sh, nc, dw, dh, r;
        logic [31:0] rx;
        logic [31:0] ry;
        logic [31:0] rv;
        sw = limit_size(int'(cfg_sw), DEF_MAX_SRC_W);
        sh = limit_size(int'(cfg_sh), DEF_MAX_SRC_H);
        nc = limit_size(int'(cfg_nc), DEF_MAX_CHANNELS);
        dw = limit_size(int'(cfg_dw), 1 << POS_W);
        dh = limit_size(int'(cfg_dh), 1 << POS_W);
        rx = $urandom;
        ry = $urandom;
        rv = $urandom;
        r = $urandom_range(0, 99);
        if (r < 45)
        begin
            load_beat(POS_W'(pick_below(sw)), POS_W'(pick_below(sh)),
                      CHAN_W'(pick_below(nc)), rv[SMP_W-1:0]);
        end
        else if (r < 85)
        begin
            fetch_beat(POS_W'(pick_below(dw)), POS_W'(pick_below(dh)),
                       CHAN_W'(pick_below(nc)));
        end
        else if (r < 93)
        begin
            load_beat(rx[POS_W-1:0], ry[POS_W-1:0], rv[17:16], rv[SMP_W-1:0]);
        end
        else
        begin
            fetch_beat(rx[POS_W-1:0], ry[POS_W-1:0], rv[17:16]);
        end
    endtask

    task automatic wait_idle();
        @(negedge clk);
        in_valid <= 1'b0;
        while (pending_count != 0)
        begin
            @(negedge clk);
        end
        repeat (SETTLE) @(negedge clk);
    endtask

    task automatic apb_write(input logic [REGIDX_W-1:0] idx, input logic [PDATA_W-1:0] data);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= data;
        @(negedge clk);
        penable <= 1'b1;
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic set_sizes(input int sw, input int sh, input int dw, input int dh,
                             input int nc, input bit noisy);
        logic [31:0] hi;
        hi = noisy ? $urandom : 32'd0;
        cfg_sw = SRC_DIM_W'(sw);
        cfg_sh = SRC_DIM_W'(sh);
        cfg_dw = DST_DIM_W'(dw);
        cfg_dh = DST_DIM_W'(dh);
        cfg_nc = NCH_W'(nc);
        apb_write(REG_SRC_WIDTH, {hi[31:SRC_DIM_W], cfg_sw});
        apb_write(REG_SRC_HEIGHT, {hi[31:SRC_DIM_W], cfg_sh});
        apb_write(REG_DST_WIDTH, {hi[31:DST_DIM_W], cfg_dw});
        apb_write(REG_DST_HEIGHT, {hi[31:DST_DIM_W], cfg_dh});
        apb_write(REG_CHANNELS, {hi[31:NCH_W], cfg_nc});
        if (noisy)
        begin
            apb_write(REG_SPARE + REGIDX_W'($urandom_range(0, 2)), $urandom);
        end
    endtask

    task automatic configure_phase(input int p);
        int sw, sh, dw, dh;
        case (p)
            0: set_sizes(1, 1, 1, 1, 1, 1'b0);
            1: set_sizes(256, 256, 1024, 1024, 4, 1'b0);
            2: set_sizes(7, 5, 13, 3, 2, 1'b1);
            3: set_sizes(300, 511, 2047, 600, 7, 1'b0);
            4: set_sizes(0, 4, 8, 8, 0, 1'b0);
            5: set_sizes(4, 4, 0, 1024, 3, 1'b1);
            6: set_sizes(256, 256, 1, 1, 4, 1'b0);
            default:
            begin
                sw = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 256) : $urandom_range(1, 16);
                sh = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 256) : $urandom_range(1, 16);
                dw = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 1024) : $urandom_range(1, 40);
                dh = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 1024) : $urandom_range(1, 40);
                set_sizes(sw, sh, dw, dh, $urandom_range(1, 4), bit'($urandom_range(0, 1)));
            end
        endcase
    endtask

    initial
    begin
        int phase_end;
        bit held;
        bit paused;
        rst_n       = 1'b0;
        psel        = 1'b0;
        penable     = 1'b0;
        pwrite      = 1'b0;
        paddr       = '0;
        pwdata      = '0;
        in_valid    = 1'b0;
        cmd         = CMD_LOAD;
        pos_x       = '0;
        pos_y       = '0;
        chan        = '0;
        sample_in   = '0;
        items_sent  = 0;
        hold_asked  = 0;
        calm        = 1'b0;
        cfg_sw      = RST_SRC_WIDTH;
        cfg_sh      = RST_SRC_HEIGHT;
        cfg_dw      = RST_DST_WIDTH;
        cfg_dh      = RST_DST_HEIGHT;
        cfg_nc      = RST_CHANNELS;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        load_beat(10'd0, 10'd0, 2'd0, 16'h0000);
        load_beat(10'd255, 10'd255, 2'd2, 16'hFFFF);
        load_beat(10'd0, 10'd255, 2'd1, 16'hA5A5);
        load_beat(10'd255, 10'd0, 2'd0, 16'h5A5A);
        load_beat(10'd256, 10'd0, 2'd0, 16'h1234);
        load_beat(10'd0, 10'd1023, 2'd0, 16'h4321);
        load_beat(10'd0, 10'd0, 2'd3, 16'hBEEF);
        load_beat(10'd1023, 10'd1023, 2'd3, 16'hFFFF);
        fetch_beat(10'd0, 10'd0, 2'd0);
        fetch_beat(10'd255, 10'd255, 2'd2);
        fetch_beat(10'd0, 10'd255, 2'd1);
        fetch_beat(10'd255, 10'd0, 2'd0);
        fetch_beat(10'd256, 10'd0, 2'd0);
        fetch_beat(10'd0, 10'd256, 2'd0);
        fetch_beat(10'd0, 10'd0, 2'd3);
        fetch_beat(10'd1023, 10'd1023, 2'd3);
        load_beat(10'd0, 10'd0, 2'd0, 16'hFFFF);
        fetch_beat(10'd0, 10'd0, 2'd0);
        fetch_beat(10'd128, 10'd127, 2'd2);

        for (int p = 0; p < PHASES; p++)
        begin
            wait_idle();
            configure_phase(p);
            calm = (p == 6);
            phase_end = items_sent + PHASE_ITEMS;
            held = 1'b0;
            paused = 1'b0;
            while (items_sent < phase_end)
            begin
                if (!held && items_sent >= phase_end - PHASE_ITEMS + 30 && (p == 1 || p == 8))
                begin
                    hold_asked++;
                    held = 1'b1;
                end
                if (!paused && items_sent >= phase_end - PHASE_ITEMS + 75 && p == 2)
                begin
                    wait_idle();
                    paused = 1'b1;
                end
                random_beat();
            end
        end
        calm = 1'b0;

        wait_idle();
        if (fail_count == 0)
        begin
            $display("RESULT: OK");
        end
        else
        begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
